// ===== rtl/cao_pkg.sv =====
// ----------------------------------------------------------------------------
// cao_pkg: shared types and constants for the calendar alarm offset block
// Holds the date record, the sequencer states, the step unit interface and
// the month length function.
// ----------------------------------------------------------------------------
package cao_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_START_HOURS   = 3'd0;
  localparam logic [2:0] REG_START_MINUTES = 3'd1;
  localparam logic [2:0] REG_START_SECONDS = 3'd2;
  localparam logic [2:0] REG_START_DAY     = 3'd3;
  localparam logic [2:0] REG_START_MONTH   = 3'd4;
  localparam logic [2:0] REG_START_YEAR    = 3'd5;

  localparam logic [6:0]  MAX_DELAY_HOURS   = 7'd99;
  localparam logic [5:0]  MAX_DELAY_MINUTES = 6'd59;
  localparam logic [6:0]  PUSH_MINUTES      = 7'd30;
  localparam logic [16:0] SEC_PER_HOUR      = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN       = 17'd60;
  localparam logic [6:0]  LAST_YEAR         = 7'd99;
  localparam logic [4:0]  MONTHS_PER_YEAR   = 5'd12;

  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } date_t;

  typedef enum logic [0:0] {
    MOD_60,
    MOD_24
  } mod_sel_t;

  typedef struct packed {
    logic       ge;
    logic [7:0] diff;
  } step_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_HR,
    ST_CMP,
    ST_SEC,
    ST_DONE
  } state_t;

  // Days in a month; the year is 2000 plus the two-digit value. Because 2000
  // is a multiple of 400, only year 0 is a 400-year leap and year 100 is the
  // only century in range.
  function automatic logic [5:0] month_len(input logic [3:0] month,
                                           input logic [6:0] year);
    logic leap;
    logic [5:0] len;
    leap = 1'b0;
    len  = 6'd31;
    if (year == 7'd0) begin
      leap = 1'b1;
    end else if (year == 7'd100) begin
      leap = 1'b0;
    end else begin
      leap = (year[1:0] == 2'b00);
    end
    unique case (month)
      4'd2:    len = leap ? 6'd29 : 6'd28;
      4'd4:    len = 6'd30;
      4'd6:    len = 6'd30;
      4'd9:    len = 6'd30;
      4'd11:   len = 6'd30;
      default: len = 6'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cao_modstep.sv =====
// ----------------------------------------------------------------------------
// cao_modstep: shared compare and subtract unit
// Compares a value against 60 or 24 and returns the reduced value.
// ----------------------------------------------------------------------------
module cao_modstep (
  input  logic [7:0]         value,
  input  cao_pkg::mod_sel_t  sel,
  output cao_pkg::step_res_t res
);

  logic [7:0] modulus;

  always_comb begin
    unique case (sel)
      cao_pkg::MOD_60: modulus = 8'd60;
      cao_pkg::MOD_24: modulus = 8'd24;
      default:         modulus = 8'd60;
    endcase
    res.ge   = (value >= modulus);
    res.diff = value - modulus;
  end

endmodule

// ===== rtl/cao_daystep.sv =====
// ----------------------------------------------------------------------------
// cao_daystep: calendar day advance
// Moves a date forward by one day through month lengths and year wrap.
// ----------------------------------------------------------------------------
module cao_daystep (
  input  cao_pkg::date_t cur,
  output cao_pkg::date_t nxt
);

  logic [5:0] day_inc;
  logic [4:0] month_inc;

  always_comb begin
    day_inc   = {1'b0, cur.day} + 6'd1;
    month_inc = {1'b0, cur.month} + 5'd1;
    nxt       = cur;
    if (day_inc > cao_pkg::month_len(cur.month, cur.year)) begin
      nxt.day = 5'd1;
      if (month_inc > cao_pkg::MONTHS_PER_YEAR) begin
        nxt.month = 4'd1;
        nxt.year  = (cur.year >= cao_pkg::LAST_YEAR) ? 7'd0 : cur.year + 7'd1;
      end else begin
        nxt.month = month_inc[3:0];
      end
    end else begin
      nxt.day = day_inc[4:0];
    end
  end

endmodule

// ===== rtl/calendar_alarm_offset.sv =====
// ----------------------------------------------------------------------------
// calendar_alarm_offset: alarm date and time from a start point and a delay
// Adds a clamped delay to the configured start time and date, then pushes
// the alarm 30 minutes later if it is not after the current clock.
// ----------------------------------------------------------------------------
// Usage: write the six start registers through cfg_we/cfg_index/cfg_wdata
// while the block is idle. An input item carries the delay and the current
// date and time; each item yields exactly one result item on the out_
// channel with the alarm fields and the pushed_back flag.
// in_stall is high from the accepting edge until the result has been loaded
// into the output register, so one item is worked on at a time.
// A single compare and subtract unit normalizes seconds, minutes and hours
// one step per cycle, and every hour wrap advances the date by one day.
// The steps taken depend on the data: up to 2 minute wraps, up to 5 day
// steps and, when pushed back, a second pass with at most one wrap per
// field. A new item is accepted only once the block is back in idle.
// Reset (rst_n low, synchronous) returns the start registers to 00:00:00 on
// day 1, month 1, year 0 and empties the output register. While the
// receiver holds out_stall on a valid result, that result stays put and a
// finished item waits in the done state before the next is accepted.
// ----------------------------------------------------------------------------
module calendar_alarm_offset (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_delay_hours,
  input  logic [7:0] in_delay_minutes,
  input  logic [4:0] in_now_hours,
  input  logic [5:0] in_now_minutes,
  input  logic [5:0] in_now_seconds,
  input  logic [4:0] in_now_day,
  input  logic [3:0] in_now_month,
  input  logic [6:0] in_now_year,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_alarm_day,
  output logic [4:0] out_alarm_hours,
  output logic [5:0] out_alarm_minutes,
  output logic [5:0] out_alarm_seconds,
  output logic [3:0] out_alarm_month,
  output logic [6:0] out_alarm_year,
  output logic       out_pushed_back
);

  // Configuration registers.
  logic [4:0] start_hours_r;
  logic [5:0] start_minutes_r;
  logic [5:0] start_seconds_r;
  logic [4:0] start_day_r;
  logic [3:0] start_month_r;
  logic [6:0] start_year_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_hours_r   <= '0;
      start_minutes_r <= '0;
      start_seconds_r <= '0;
      start_day_r     <= 5'd1;
      start_month_r   <= 4'd1;
      start_year_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cao_pkg::REG_START_HOURS:   start_hours_r   <= cfg_wdata[4:0];
        cao_pkg::REG_START_MINUTES: start_minutes_r <= cfg_wdata[5:0];
        cao_pkg::REG_START_SECONDS: start_seconds_r <= cfg_wdata[5:0];
        cao_pkg::REG_START_DAY:     start_day_r     <= cfg_wdata[4:0];
        cao_pkg::REG_START_MONTH:   start_month_r   <= cfg_wdata[3:0];
        cao_pkg::REG_START_YEAR:    start_year_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Working registers.
  cao_pkg::state_t state_r, state_nxt;
  logic            pass2_r, pass2_nxt;
  logic            pushed_r, pushed_nxt;
  logic [7:0]      hr_r, hr_nxt;
  logic [6:0]      mm_r, mm_nxt;
  logic [5:0]      ss_r, ss_nxt;
  cao_pkg::date_t  date_r, date_nxt;
  logic [4:0]      now_hours_r, now_hours_nxt;
  logic [5:0]      now_minutes_r, now_minutes_nxt;
  logic [5:0]      now_seconds_r, now_seconds_nxt;
  cao_pkg::date_t  now_date_r, now_date_nxt;

  logic            out_valid_r, out_valid_nxt;
  cao_pkg::date_t  out_date_r, out_date_nxt;
  logic [4:0]      out_hours_r, out_hours_nxt;
  logic [5:0]      out_minutes_r, out_minutes_nxt;
  logic [5:0]      out_seconds_r, out_seconds_nxt;
  logic            out_pushed_r, out_pushed_nxt;

  // Shared step unit and day stepper.
  logic [7:0]          step_val;
  cao_pkg::mod_sel_t   step_sel;
  cao_pkg::step_res_t  step_res;
  cao_pkg::date_t      date_next_day;

  cao_modstep u_modstep (
    .value (step_val),
    .sel   (step_sel),
    .res   (step_res)
  );

  cao_daystep u_daystep (
    .cur (date_r),
    .nxt (date_next_day)
  );

  logic [6:0]  dh_clamp;
  logic [5:0]  dm_clamp;
  logic [16:0] alarm_secs;
  logic [16:0] now_secs;
  logic        date_later;
  logic        date_equal;
  logic        past;

  always_comb begin
    dh_clamp = (in_delay_hours > {1'b0, cao_pkg::MAX_DELAY_HOURS}) ?
               cao_pkg::MAX_DELAY_HOURS : in_delay_hours[6:0];
    dm_clamp = (in_delay_minutes > {2'b0, cao_pkg::MAX_DELAY_MINUTES}) ?
               cao_pkg::MAX_DELAY_MINUTES : in_delay_minutes[5:0];

    // Seconds of day for the alarm and for the current clock; the alarm
    // minutes and hours are already normalized here.
    alarm_secs = 17'(hr_r) * cao_pkg::SEC_PER_HOUR + 17'(mm_r) * cao_pkg::SEC_PER_MIN
               + 17'(ss_r);
    now_secs   = 17'(now_hours_r) * cao_pkg::SEC_PER_HOUR
               + 17'(now_minutes_r) * cao_pkg::SEC_PER_MIN + 17'(now_seconds_r);

    date_later = (now_date_r.year > date_r.year)
              || (now_date_r.year == date_r.year && now_date_r.month > date_r.month)
              || (now_date_r.year == date_r.year && now_date_r.month == date_r.month
                  && now_date_r.day > date_r.day);
    date_equal = (now_date_r == date_r);
    past       = date_later || (date_equal && (alarm_secs <= now_secs));

    unique case (state_r)
      cao_pkg::ST_SEC: begin
        step_val = {2'b0, ss_r};
        step_sel = cao_pkg::MOD_60;
      end
      cao_pkg::ST_MIN: begin
        step_val = {1'b0, mm_r};
        step_sel = cao_pkg::MOD_60;
      end
      default: begin
        step_val = hr_r;
        step_sel = cao_pkg::MOD_24;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    pass2_nxt       = pass2_r;
    pushed_nxt      = pushed_r;
    hr_nxt          = hr_r;
    mm_nxt          = mm_r;
    ss_nxt          = ss_r;
    date_nxt        = date_r;
    now_hours_nxt   = now_hours_r;
    now_minutes_nxt = now_minutes_r;
    now_seconds_nxt = now_seconds_r;
    now_date_nxt    = now_date_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_date_nxt    = out_date_r;
    out_hours_nxt   = out_hours_r;
    out_minutes_nxt = out_minutes_r;
    out_seconds_nxt = out_seconds_r;
    out_pushed_nxt  = out_pushed_r;
    in_stall        = (state_r != cao_pkg::ST_IDLE);

    unique case (state_r)
      cao_pkg::ST_IDLE: begin
        if (in_valid) begin
          hr_nxt             = 8'(start_hours_r) + 8'(dh_clamp);
          mm_nxt             = 7'(start_minutes_r) + 7'(dm_clamp);
          ss_nxt             = start_seconds_r;
          date_nxt.day       = start_day_r;
          date_nxt.month     = start_month_r;
          date_nxt.year      = start_year_r;
          now_hours_nxt      = in_now_hours;
          now_minutes_nxt    = in_now_minutes;
          now_seconds_nxt    = in_now_seconds;
          now_date_nxt.day   = in_now_day;
          now_date_nxt.month = in_now_month;
          now_date_nxt.year  = in_now_year;
          pass2_nxt          = 1'b0;
          pushed_nxt         = 1'b0;
          state_nxt          = cao_pkg::ST_MIN;
        end
      end
      cao_pkg::ST_SEC: begin
        if (step_res.ge) begin
          ss_nxt = step_res.diff[5:0];
          mm_nxt = mm_r + 7'd1;
        end else begin
          state_nxt = cao_pkg::ST_MIN;
        end
      end
      cao_pkg::ST_MIN: begin
        if (step_res.ge) begin
          mm_nxt = step_res.diff[6:0];
          hr_nxt = hr_r + 8'd1;
        end else begin
          state_nxt = cao_pkg::ST_HR;
        end
      end
      cao_pkg::ST_HR: begin
        // Each wrap of the hour is one whole day.
        if (step_res.ge) begin
          hr_nxt   = step_res.diff;
          date_nxt = date_next_day;
        end else begin
          state_nxt = pass2_r ? cao_pkg::ST_DONE : cao_pkg::ST_CMP;
        end
      end
      cao_pkg::ST_CMP: begin
        if (past) begin
          pushed_nxt = 1'b1;
          pass2_nxt  = 1'b1;
          mm_nxt     = mm_r + cao_pkg::PUSH_MINUTES;
          state_nxt  = cao_pkg::ST_SEC;
        end else begin
          state_nxt = cao_pkg::ST_DONE;
        end
      end
      cao_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_date_nxt    = date_r;
          out_hours_nxt   = hr_r[4:0];
          out_minutes_nxt = mm_r[5:0];
          out_seconds_nxt = ss_r;
          out_pushed_nxt  = pushed_r;
          state_nxt       = cao_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cao_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cao_pkg::ST_IDLE;
      pass2_r     <= 1'b0;
      pushed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass2_r     <= pass2_nxt;
      pushed_r    <= pushed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hr_r          <= hr_nxt;
    mm_r          <= mm_nxt;
    ss_r          <= ss_nxt;
    date_r        <= date_nxt;
    now_hours_r   <= now_hours_nxt;
    now_minutes_r <= now_minutes_nxt;
    now_seconds_r <= now_seconds_nxt;
    now_date_r    <= now_date_nxt;
    out_date_r    <= out_date_nxt;
    out_hours_r   <= out_hours_nxt;
    out_minutes_r <= out_minutes_nxt;
    out_seconds_r <= out_seconds_nxt;
    out_pushed_r  <= out_pushed_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_alarm_day     = out_date_r.day;
  assign out_alarm_hours   = out_hours_r;
  assign out_alarm_minutes = out_minutes_r;
  assign out_alarm_seconds = out_seconds_r;
  assign out_alarm_month   = out_date_r.month;
  assign out_alarm_year    = out_date_r.year;
  assign out_pushed_back   = out_pushed_r;

  // The comparison only ever sees normalized minutes and hours.
  a_cmp_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cao_pkg::ST_CMP |-> (mm_r < 7'd60 && hr_r < 8'd24))
    else $error("time not normalized before comparison");

  // The push-back pass can cross midnight at most once.
  a_pass2_one_day: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cao_pkg::ST_HR && pass2_r) |-> hr_r <= 8'd24)
    else $error("push-back pass carries more than one day");

  // Seconds are normalized only after a push back.
  a_sec_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cao_pkg::ST_SEC |-> (pass2_r && pushed_r))
    else $error("seconds step outside the push-back pass");

  // An accepted item starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == cao_pkg::ST_MIN)
    else $error("accepted item did not start the sequencer");

endmodule

// ===== bench/alarm_offset_checker.sv =====
// ----------------------------------------------------------------------------
// alarm_offset_checker: scoreboard for the calendar alarm offset block
// Follows the start registers through the write port, works out the alarm
// for every accepted input item and compares each accepted result item
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module alarm_offset_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_delay_hours,
  input  logic [7:0] in_delay_minutes,
  input  logic [4:0] in_now_hours,
  input  logic [5:0] in_now_minutes,
  input  logic [5:0] in_now_seconds,
  input  logic [4:0] in_now_day,
  input  logic [3:0] in_now_month,
  input  logic [6:0] in_now_year,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [4:0] out_alarm_day,
  input  logic [4:0] out_alarm_hours,
  input  logic [5:0] out_alarm_minutes,
  input  logic [5:0] out_alarm_seconds,
  input  logic [3:0] out_alarm_month,
  input  logic [6:0] out_alarm_year,
  input  logic       out_pushed_back,
  output int         mismatch_count,
  output int         alarms_waiting,
  output int         alarms_checked,
  output int         pushed_seen
);

  typedef struct packed {
    logic [4:0] day;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [3:0] month;
    logic [6:0] year;
    logic       pushed;
  } alarm_t;

  // Wide enough to hold day 32 and month 16 before they are folded back.
  typedef struct packed {
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
  } cal_date_t;

  logic [4:0] start_hours;
  logic [5:0] start_minutes;
  logic [5:0] start_seconds;
  logic [4:0] start_day;
  logic [3:0] start_month;
  logic [6:0] start_year;

  alarm_t alarm_q[$];

  function automatic int unsigned month_days(input logic [7:0] month, input logic [7:0] year);
    int unsigned full;
    logic        leap;
    full = 2000 + year;
    leap = (full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0));
    case (month)
      8'd2:                     return leap ? 29 : 28;
      8'd4, 8'd6, 8'd9, 8'd11: return 30;
      default:                  return 31;
    endcase
  endfunction

  // Months outside 1..12 count as 31 days and still roll into January.
  function automatic cal_date_t next_date(input cal_date_t c);
    cal_date_t r;
    r = c;
    r.day = c.day + 8'd1;
    if (r.day > month_days(c.month, c.year)) begin
      r.day   = 8'd1;
      r.month = c.month + 8'd1;
      if (r.month > 8'd12) begin
        r.month = 8'd1;
        r.year  = (c.year >= 8'd99) ? 8'd0 : c.year + 8'd1;
      end
    end
    return r;
  endfunction

  function automatic alarm_t predict_alarm(input logic [7:0] dh_in, input logic [7:0] dm_in,
                                           input logic [4:0] nh, input logic [5:0] nm,
                                           input logic [5:0] ns, input logic [4:0] nd,
                                           input logic [3:0] nmo, input logic [6:0] ny);
    int unsigned dh, dm, total, hh, mm, ss, secs, pushed_secs;
    logic        late;
    cal_date_t   dt;
    alarm_t      res;
    dh = (dh_in > 8'd99) ? 99 : dh_in;
    dm = (dm_in > 8'd59) ? 59 : dm_in;
    total = start_hours * 60 + start_minutes + dh * 60 + dm;
    hh = (total % 1440) / 60;
    mm = total % 60;
    ss = start_seconds;
    dt.day   = 8'(start_day);
    dt.month = 8'(start_month);
    dt.year  = 8'(start_year);
    repeat (total / 1440) dt = next_date(dt);
    secs = hh * 3600 + mm * 60 + ss;
    if (ny != dt.year) late = ny > dt.year;
    else if (nmo != dt.month) late = nmo > dt.month;
    else if (nd != dt.day) late = nd > dt.day;
    else late = secs <= nh * 3600 + nm * 60 + ns;
    // An alarm that is not in the future moves 30 minutes on, at most one day.
    if (late) begin
      pushed_secs = secs + 1800;
      hh = (pushed_secs % 86400) / 3600;
      mm = (pushed_secs % 3600) / 60;
      ss = pushed_secs % 60;
      repeat (pushed_secs / 86400) dt = next_date(dt);
    end
    res.day     = dt.day[4:0];
    res.hours   = hh[4:0];
    res.minutes = mm[5:0];
    res.seconds = ss[5:0];
    res.month   = dt.month[3:0];
    res.year    = dt.year[6:0];
    res.pushed  = late;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    alarm_t got;
    alarm_t want;
    if (!rst_n) begin
      start_hours   = 5'd0;
      start_minutes = 6'd0;
      start_seconds = 6'd0;
      start_day     = 5'd1;
      start_month   = 4'd1;
      start_year    = 7'd0;
    end else begin
      if (in_valid && !in_stall) begin
        alarm_q.push_back(predict_alarm(in_delay_hours, in_delay_minutes, in_now_hours,
                                        in_now_minutes, in_now_seconds, in_now_day,
                                        in_now_month, in_now_year));
      end
      if (out_valid && !out_stall) begin
        got = '{out_alarm_day, out_alarm_hours, out_alarm_minutes, out_alarm_seconds,
                out_alarm_month, out_alarm_year, out_pushed_back};
        if (alarm_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result item with no alarm predicted", $time);
          end
        end else begin
          want = alarm_q.pop_front();
          alarms_checked++;
          if (got.pushed === 1'b1) pushed_seen++;
          if (got.day !== want.day || got.hours !== want.hours ||
              got.minutes !== want.minutes || got.seconds !== want.seconds ||
              got.month !== want.month || got.year !== want.year ||
              got.pushed !== want.pushed) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: alarm mismatch, expected %0d/%0d/%0d %0d:%0d:%0d pushed %0b",
                       $time, want.day, want.month, want.year, want.hours, want.minutes,
                       want.seconds, want.pushed);
              $display("%0t:                 actual %0d/%0d/%0d %0d:%0d:%0d pushed %0b",
                       $time, got.day, got.month, got.year, got.hours, got.minutes,
                       got.seconds, got.pushed);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          cao_pkg::REG_START_HOURS:   start_hours   = cfg_wdata[4:0];
          cao_pkg::REG_START_MINUTES: start_minutes = cfg_wdata[5:0];
          cao_pkg::REG_START_SECONDS: start_seconds = cfg_wdata[5:0];
          cao_pkg::REG_START_DAY:     start_day     = cfg_wdata[4:0];
          cao_pkg::REG_START_MONTH:   start_month   = cfg_wdata[3:0];
          cao_pkg::REG_START_YEAR:    start_year    = cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
    alarms_waiting = alarm_q.size();
  end

endmodule

// ===== bench/calendar_alarm_offset_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_alarm_offset_tb: top level testbench for calendar_alarm_offset
// Drives directed calendar corner cases and then random alarm requests over
// many start settings, with random idle bursts on both channels. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module calendar_alarm_offset_tb;

  localparam logic [2:0] REG_FIRST_UNUSED = 3'd6;
  localparam int         CYCLE_LIMIT      = 200000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [6:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_delay_hours;
  logic [7:0] in_delay_minutes;
  logic [4:0] in_now_hours;
  logic [5:0] in_now_minutes;
  logic [5:0] in_now_seconds;
  logic [4:0] in_now_day;
  logic [3:0] in_now_month;
  logic [6:0] in_now_year;
  logic       out_valid;
  logic       out_stall;
  logic [4:0] out_alarm_day;
  logic [4:0] out_alarm_hours;
  logic [5:0] out_alarm_minutes;
  logic [5:0] out_alarm_seconds;
  logic [3:0] out_alarm_month;
  logic [6:0] out_alarm_year;
  logic       out_pushed_back;

  int mismatch_count;
  int alarms_waiting;
  int alarms_checked;
  int pushed_seen;

  // Start point as last written, used to steer the current clock near the alarm.
  int unsigned cur_h, cur_m, cur_s, cur_day, cur_mon, cur_yr;
  int in_gap_pct;
  int out_stall_pct;
  int items_sent;
  int settings_used;
  int cycle_count;

  calendar_alarm_offset i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_delay_hours    (in_delay_hours),
    .in_delay_minutes  (in_delay_minutes),
    .in_now_hours      (in_now_hours),
    .in_now_minutes    (in_now_minutes),
    .in_now_seconds    (in_now_seconds),
    .in_now_day        (in_now_day),
    .in_now_month      (in_now_month),
    .in_now_year       (in_now_year),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_alarm_day     (out_alarm_day),
    .out_alarm_hours   (out_alarm_hours),
    .out_alarm_minutes (out_alarm_minutes),
    .out_alarm_seconds (out_alarm_seconds),
    .out_alarm_month   (out_alarm_month),
    .out_alarm_year    (out_alarm_year),
    .out_pushed_back   (out_pushed_back)
  );

  alarm_offset_checker i_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_delay_hours    (in_delay_hours),
    .in_delay_minutes  (in_delay_minutes),
    .in_now_hours      (in_now_hours),
    .in_now_minutes    (in_now_minutes),
    .in_now_seconds    (in_now_seconds),
    .in_now_day        (in_now_day),
    .in_now_month      (in_now_month),
    .in_now_year       (in_now_year),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_alarm_day     (out_alarm_day),
    .out_alarm_hours   (out_alarm_hours),
    .out_alarm_minutes (out_alarm_minutes),
    .out_alarm_seconds (out_alarm_seconds),
    .out_alarm_month   (out_alarm_month),
    .out_alarm_year    (out_alarm_year),
    .out_pushed_back   (out_pushed_back),
    .mismatch_count    (mismatch_count),
    .alarms_waiting    (alarms_waiting),
    .alarms_checked    (alarms_checked),
    .pushed_seen       (pushed_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Run timed out after %0d cycles", CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver side: stall bursts of random length, started at random.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < out_stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Lowers valid and waits until every predicted alarm has come out.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (alarms_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [2:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
  endtask

  task automatic set_start(input logic [6:0] h, input logic [6:0] m, input logic [6:0] s,
                           input logic [6:0] d, input logic [6:0] mo, input logic [6:0] y);
    drain();
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_FIRST_UNUSED + 3'($urandom_range(0, 1)), 7'($urandom));
    end
    write_reg(cao_pkg::REG_START_HOURS, h);
    write_reg(cao_pkg::REG_START_MINUTES, m);
    write_reg(cao_pkg::REG_START_SECONDS, s);
    write_reg(cao_pkg::REG_START_DAY, d);
    write_reg(cao_pkg::REG_START_MONTH, mo);
    write_reg(cao_pkg::REG_START_YEAR, y);
    @(negedge clk);
    cfg_we = 1'b0;
    cur_h   = h[4:0];
    cur_m   = m[5:0];
    cur_s   = s[5:0];
    cur_day = d[4:0];
    cur_mon = mo[3:0];
    cur_yr  = y;
    settings_used++;
  endtask

  task automatic send_item(input logic [7:0] dh, input logic [7:0] dm,
                           input logic [4:0] nh, input logic [5:0] nm, input logic [5:0] ns,
                           input logic [4:0] nd, input logic [3:0] nmo, input logic [6:0] ny);
    @(negedge clk);
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_delay_hours   = dh;
    in_delay_minutes = dm;
    in_now_hours     = nh;
    in_now_minutes   = nm;
    in_now_seconds   = ns;
    in_now_day       = nd;
    in_now_month     = nmo;
    in_now_year      = ny;
    in_valid         = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Most items place the current clock on or next to the alarm so that the
  // date and time comparison is decided by its last fields.
  task automatic random_item();
    int unsigned dh, dm, total, days, a_secs, n_secs, sel;
    logic [4:0] nd;
    logic [3:0] nmo;
    logic [6:0] ny;
    sel = $urandom_range(0, 9);
    if (sel == 9) begin
      send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (sel >= 7) begin
      send_item($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 23),
                $urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(1, 31),
                $urandom_range(1, 12), $urandom_range(0, 99));
    end else begin
      case ($urandom_range(0, 3))
        0:       dh = $urandom_range(0, 255);
        1:       dh = $urandom_range(95, 110);
        default: dh = $urandom_range(0, 30);
      endcase
      dm = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 65);
      total  = cur_h * 60 + cur_m + ((dh > 99) ? 99 : dh) * 60 + ((dm > 59) ? 59 : dm);
      days   = total / 1440;
      a_secs = ((total % 1440) / 60) * 3600 + (total % 60) * 60 + cur_s;
      case ($urandom_range(0, 5))
        0, 1:    n_secs = a_secs;
        2:       n_secs = a_secs + 1;
        3:       n_secs = (a_secs > 0) ? a_secs - 1 : 0;
        default: n_secs = $urandom_range(0, 86399);
      endcase
      nd = 5'(cur_day + days);
      case ($urandom_range(0, 5))
        0:       nd = nd - 5'd1;
        1:       nd = nd + 5'd1;
        default: ;
      endcase
      nmo = cur_mon[3:0];
      ny  = cur_yr[6:0];
      if ($urandom_range(0, 9) == 0) nmo = ($urandom_range(0, 1) == 0) ? nmo + 4'd1 : nmo - 4'd1;
      if ($urandom_range(0, 9) == 0) ny = ($urandom_range(0, 1) == 0) ? ny + 7'd1 : ny - 7'd1;
      send_item(dh, dm, n_secs / 3600, (n_secs % 3600) / 60, n_secs % 60, nd, nmo, ny);
    end
  endtask

  initial begin : stimulus
    int phase;
    int k;
    int kind;
    int count;
    logic [6:0] yr;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = cao_pkg::REG_START_HOURS;
    cfg_wdata        = 7'd0;
    in_valid         = 1'b0;
    in_delay_hours   = 8'd0;
    in_delay_minutes = 8'd0;
    in_now_hours     = 5'd0;
    in_now_minutes   = 6'd0;
    in_now_seconds   = 6'd0;
    in_now_day       = 5'd1;
    in_now_month     = 4'd1;
    in_now_year      = 7'd0;
    cur_h            = 0;
    cur_m            = 0;
    cur_s            = 0;
    cur_day          = 1;
    cur_mon          = 1;
    cur_yr           = 0;
    in_gap_pct       = 20;
    out_stall_pct    = 15;
    items_sent       = 0;
    settings_used    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset start point: equal clock, widest fields, clamped delays.
    send_item(0, 0, 0, 0, 0, 1, 1, 0);
    send_item(255, 255, 31, 63, 63, 31, 15, 127);
    send_item(99, 59, 0, 0, 0, 0, 0, 0);
    send_item(100, 60, 23, 59, 59, 5, 1, 0);
    send_item(0, 0, 0, 0, 0, 0, 0, 0);

    // Last second of year 99: push back and delay both wrap the year.
    set_start(23, 59, 59, 31, 12, 99);
    send_item(0, 0, 23, 59, 58, 31, 12, 99);
    send_item(0, 0, 23, 59, 59, 31, 12, 99);
    send_item(0, 1, 0, 0, 0, 1, 1, 0);
    send_item(0, 0, 0, 0, 0, 1, 1, 100);

    // February of a leap year, with a later day and a later month in now.
    set_start(23, 0, 0, 28, 2, 0);
    send_item(1, 0, 0, 0, 0, 1, 1, 0);
    send_item(25, 0, 0, 0, 0, 1, 4, 0);
    send_item(0, 0, 23, 0, 0, 28, 2, 0);
    send_item(0, 40, 23, 40, 0, 29, 2, 0);

    // Year 2100 is not a leap year; year 2001 neither.
    set_start(23, 30, 0, 28, 2, 100);
    send_item(0, 30, 0, 0, 0, 1, 1, 0);
    send_item(0, 0, 23, 30, 0, 28, 2, 100);
    set_start(23, 59, 0, 28, 2, 1);
    send_item(0, 1, 0, 0, 0, 1, 1, 0);

    // Start fields beyond their ranges: day zero, month 13, seconds 63.
    set_start(31, 63, 63, 0, 13, 127);
    send_item(0, 0, 0, 0, 0, 0, 0, 0);
    send_item(99, 59, 31, 63, 63, 31, 15, 127);
    send_item(0, 0, 8, 3, 63, 1, 13, 127);

    set_start(23, 59, 59, 31, 15, 99);
    send_item(0, 1, 0, 0, 0, 1, 1, 0);

    for (phase = 0; phase < 12; phase++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        set_start($urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                  $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 99));
      end else if (kind < 7) begin
        case ($urandom_range(0, 4))
          0:       yr = 7'd0;
          1:       yr = 7'd99;
          2:       yr = 7'd100;
          3:       yr = 7'd4;
          default: yr = 7'($urandom_range(0, 127));
        endcase
        set_start($urandom_range(20, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                  $urandom_range(27, 31), $urandom_range(1, 12), yr);
      end else begin
        set_start($urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 127));
      end
      if (phase == 11) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
        count         = 80;
      end else begin
        case ($urandom_range(0, 2))
          0:       in_gap_pct = 0;
          1:       in_gap_pct = 10;
          default: in_gap_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0:       out_stall_pct = 0;
          1:       out_stall_pct = 10;
          default: out_stall_pct = 35;
        endcase
        count = 42;
      end
      for (k = 0; k < count; k++) begin
        // Once, in the middle of phase 3, hold the sender until the block has emptied out.
        if (phase == 3 && k == count / 2) drain();
        random_item();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("Sent %0d alarm requests over %0d start settings plus the reset one;",
             items_sent, settings_used);
    $display("%0d results checked, %0d of them pushed back, %0d mismatches.",
             alarms_checked, pushed_seen, mismatch_count);
    if (mismatch_count == 0 && alarms_waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
